@@ hw/rtl/fpsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fpsc_pkg;

    localparam int MAX_LEVEL_DEFAULT   = 15;
    localparam int COUNT_WIDTH_DEFAULT = 64;
    localparam int LEVEL_WIDTH         = 4;
    localparam int LABEL_WIDTH         = 4;
    localparam int OUT_COUNT_WIDTH     = 64;

    localparam logic [LEVEL_WIDTH-1:0] LEVEL_RESET = 4'd6;

    typedef struct packed {
        logic [LABEL_WIDTH-1:0] label;
        logic                   negative;
        logic                   last;
    } in_t;

    typedef struct packed {
        logic signed [OUT_COUNT_WIDTH-1:0] count;
        logic                              overflow;
    } out_t;

endpackage

`default_nettype wire

@@ hw/rtl/fusion_pair_signed_count_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Signed pair-count unit over SU(2) level-k fusion. A table of signed counts indexed by
// label pairs (a,b) lives in one RAM; each input beat walks every pair, and for each
// nonzero count does one read-add-write on a scratch RAM per fusion output, left side
// then right side, through a single shared adder. After the walk the unit copies the
// scratch table back into the table and clears it; on a last beat it instead loads the
// result register, then restores the unit table and clears the scratch table. Each
// scratch read-add-write is read in S_ENUM and written in S_ACC. After reset the unit
// runs a clearing sweep over the P = (MAX_LEVEL+1)^2 pairs before it raises in_ready;
// level writes must be made only while the unit is idle, which the unit itself does
// not enforce.
module fusion_pair_signed_count_unit
    import fpsc_pkg::*;
#(
    parameter int MAX_LEVEL   = MAX_LEVEL_DEFAULT,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_t                    in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_t                        out_data,
    input  wire logic                   cfg_write_en,
    input  wire logic [LEVEL_WIDTH-1:0] cfg_write_data
);

    localparam int SIDE  = MAX_LEVEL + 1;
    localparam int IDX   = $clog2(SIDE);
    localparam int W     = ((IDX > LABEL_WIDTH) ? IDX : LABEL_WIDTH) + 2;
    localparam int DEPTH = 1 << (2 * IDX);
    localparam int AW    = 2 * IDX;
    localparam int CW    = COUNT_WIDTH;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD_CUR = 4'd1;
    localparam logic [3:0] S_GOT    = 4'd2;
    localparam logic [3:0] S_ENUM   = 4'd3;
    localparam logic [3:0] S_ACC    = 4'd4;
    localparam logic [3:0] S_NEXTP  = 4'd5;
    localparam logic [3:0] S_CPY_RD = 4'd6;
    localparam logic [3:0] S_CPY_WR = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;
    localparam logic [3:0] S_CLR    = 4'd9;

    localparam logic [IDX-1:0] LAST_IDX = IDX'(SIDE - 1);
    localparam logic [CW-1:0]  MIN_CNT  = {1'b1, {(CW-1){1'b0}}};

    // control
    logic [3:0]             state_reg, state_next;
    logic [IDX-1:0]         a_reg, a_next;
    logic [IDX-1:0]         b_reg, b_next;
    logic                   side_reg, side_next;
    logic                   ovf_reg, ovf_next;
    logic [LEVEL_WIDTH-1:0] level_reg, level_next;
    logic                   out_valid_reg, out_valid_next;

    // payload
    logic signed [W-1:0]    o_reg, o_next;
    logic signed [W-1:0]    hi_reg, hi_next;
    logic [CW-1:0]          c_reg, c_next;
    logic [CW-1:0]          sc_reg, sc_next;
    logic [CW-1:0]          res_reg, res_next;
    logic [LABEL_WIDTH-1:0] lab_reg, lab_next;
    logic                   neg_reg, neg_next;
    logic                   last_reg, last_next;
    out_t                   out_data_reg, out_data_next;

    // table ports
    logic [CW-1:0] cur_rdata, cur_wdata, nxt_rdata, nxt_wdata;
    logic [AW-1:0] cur_wr_addr, nxt_rd_addr, nxt_wr_addr;
    logic          cur_we, nxt_we;

    logic [AW-1:0]       pair_addr, tgt_addr;
    logic                pair_end;
    logic signed [W-1:0] lv_w;
    logic signed [W-1:0] lo_a, hi_a, lo_b, hi_b;
    logic                side_done;
    logic [CW-1:0]       addend, sum;
    logic                sum_ovf;

    function automatic logic signed [W-1:0] fus_lo(
        input logic [IDX-1:0]         x,
        input logic [LABEL_WIDTH-1:0] l
    );
        logic signed [W-1:0] d;
        d = signed'(W'(x)) - signed'(W'(l));
        return (d < 0) ? -d : d;
    endfunction

    function automatic logic signed [W-1:0] fus_hi(
        input logic [IDX-1:0]         x,
        input logic [LABEL_WIDTH-1:0] l,
        input logic signed [W-1:0]    lv
    );
        logic signed [W-1:0] s;
        logic signed [W-1:0] alt;
        s   = signed'(W'(x)) + signed'(W'(l));
        alt = (lv <<< 1) - s;
        return (alt < s) ? alt : s;
    endfunction

    assign lv_w = (W'(level_reg) > W'(MAX_LEVEL)) ? W'(MAX_LEVEL) : W'(level_reg);

    assign lo_a = fus_lo(a_reg, lab_reg);
    assign hi_a = fus_hi(a_reg, lab_reg, lv_w);
    assign lo_b = fus_lo(b_reg, lab_reg);
    assign hi_b = fus_hi(b_reg, lab_reg, lv_w);

    assign pair_addr = {a_reg, b_reg};
    assign tgt_addr  = side_reg ? {a_reg, o_reg[IDX-1:0]} : {o_reg[IDX-1:0], b_reg};
    assign pair_end  = (a_reg == LAST_IDX) && (b_reg == LAST_IDX);
    assign side_done = (o_reg > hi_reg) || (o_reg >= signed'(W'(SIDE)));

    // shared accumulate adder
    assign addend  = side_reg ? sc_reg : c_reg;
    assign sum     = nxt_rdata + addend;
    assign sum_ovf = (nxt_rdata[CW-1] == addend[CW-1]) && (sum[CW-1] != nxt_rdata[CW-1]);

    assign nxt_rd_addr = (state_reg == S_CPY_RD) ? pair_addr : tgt_addr;

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        side_next      = side_reg;
        ovf_next       = ovf_reg;
        level_next     = cfg_write_en ? cfg_write_data : level_reg;
        out_valid_next = out_valid_reg && !out_ready;
        o_next         = o_reg;
        hi_next        = hi_reg;
        c_next         = c_reg;
        sc_next        = sc_reg;
        res_next       = res_reg;
        lab_next       = lab_reg;
        neg_next       = neg_reg;
        last_next      = last_reg;
        out_data_next  = out_data_reg;
        cur_we         = 1'b0;
        cur_wr_addr    = pair_addr;
        cur_wdata      = nxt_rdata;
        nxt_we         = 1'b0;
        nxt_wr_addr    = pair_addr;
        nxt_wdata      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    lab_next   = in_data.label;
                    neg_next   = in_data.negative;
                    last_next  = in_data.last;
                    a_next     = '0;
                    b_next     = '0;
                    res_next   = '0;
                    state_next = S_RD_CUR;
                end
            end
            S_RD_CUR:
            begin
                state_next = S_GOT;
            end
            S_GOT:
            begin
                c_next  = cur_rdata;
                sc_next = neg_reg ? (CW'(0) - cur_rdata) : cur_rdata;
                if (neg_reg && (cur_rdata == MIN_CNT))
                begin
                    ovf_next = 1'b1;
                end
                if (cur_rdata == '0)
                begin
                    // zero count adds nothing and cannot overflow
                    state_next = S_NEXTP;
                end
                else
                begin
                    side_next  = 1'b0;
                    o_next     = lo_a;
                    hi_next    = hi_a;
                    state_next = S_ENUM;
                end
            end
            S_ENUM:
            begin
                if (side_done)
                begin
                    if (!side_reg)
                    begin
                        side_next = 1'b1;
                        o_next    = lo_b;
                        hi_next   = hi_b;
                    end
                    else
                    begin
                        state_next = S_NEXTP;
                    end
                end
                else
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                nxt_we      = 1'b1;
                nxt_wr_addr = tgt_addr;
                nxt_wdata   = sum;
                if (sum_ovf)
                begin
                    ovf_next = 1'b1;
                end
                if (tgt_addr == '0)
                begin
                    res_next = sum;
                end
                o_next     = o_reg + W'(2);
                state_next = S_ENUM;
            end
            S_NEXTP:
            begin
                if (pair_end)
                begin
                    a_next     = '0;
                    b_next     = '0;
                    state_next = last_reg ? S_EMIT : S_CPY_RD;
                end
                else
                begin
                    if (b_reg == LAST_IDX)
                    begin
                        b_next = '0;
                        a_next = a_reg + IDX'(1);
                    end
                    else
                    begin
                        b_next = b_reg + IDX'(1);
                    end
                    state_next = S_RD_CUR;
                end
            end
            S_CPY_RD:
            begin
                state_next = S_CPY_WR;
            end
            S_CPY_WR:
            begin
                // move scratch entry into the table and zero it behind
                cur_we    = 1'b1;
                cur_wdata = nxt_rdata;
                nxt_we    = 1'b1;
                nxt_wdata = '0;
                if (pair_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    if (b_reg == LAST_IDX)
                    begin
                        b_next = '0;
                        a_next = a_reg + IDX'(1);
                    end
                    else
                    begin
                        b_next = b_reg + IDX'(1);
                    end
                    state_next = S_CPY_RD;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.count    = OUT_COUNT_WIDTH'($signed(res_reg));
                    out_data_next.overflow = ovf_reg;
                    ovf_next               = 1'b0;
                    state_next             = S_CLR;
                end
            end
            S_CLR:
            begin
                // table back to the unit, scratch to zero
                cur_we    = 1'b1;
                cur_wdata = (pair_addr == '0) ? CW'(1) : '0;
                nxt_we    = 1'b1;
                nxt_wdata = '0;
                if (pair_end)
                begin
                    a_next     = '0;
                    b_next     = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    if (b_reg == LAST_IDX)
                    begin
                        b_next = '0;
                        a_next = a_reg + IDX'(1);
                    end
                    else
                    begin
                        b_next = b_reg + IDX'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            a_reg         <= '0;
            b_reg         <= '0;
            side_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            level_reg     <= LEVEL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            side_reg      <= side_next;
            ovf_reg       <= ovf_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_reg        <= o_next;
        hi_reg       <= hi_next;
        c_reg        <= c_next;
        sc_reg       <= sc_next;
        res_reg      <= res_next;
        lab_reg      <= lab_next;
        neg_reg      <= neg_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    fpsc_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_cur_ram (
        .clk     (clk),
        .wr_en   (cur_we),
        .wr_addr (cur_wr_addr),
        .wr_data (cur_wdata),
        .rd_addr (pair_addr),
        .rd_data (cur_rdata)
    );

    fpsc_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_nxt_ram (
        .clk     (clk),
        .wr_en   (nxt_we),
        .wr_addr (nxt_wr_addr),
        .wr_data (nxt_wdata),
        .rd_addr (nxt_rd_addr),
        .rd_data (nxt_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fpsc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fpsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
